FILE: rtl/midi_byte_stream_event_parser_core_assert.svh
// Assertion macros for the MIDI parser core.
// They sample on clock; all but MBSEP_ASSERT_NEXT_ALWAYS are disabled while reset is high.
`ifndef MIDI_BYTE_STREAM_EVENT_PARSER_CORE_ASSERT_SVH
`define MIDI_BYTE_STREAM_EVENT_PARSER_CORE_ASSERT_SVH

// Same-cycle implication
`define MBSEP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define MBSEP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is checked during reset as well
`define MBSEP_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mbsep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbsep_pkg;

   // field widths
   localparam int RxByteWidth  = 8;
   localparam int CodeWidth    = 9;
   localparam int ValueWidth   = 7;
   localparam int ChannelWidth = 4;
   localparam int ListenWidth  = 5;
   localparam int RspDataWidth = 24;   // 20 payload bits padded to whole bytes

   // listen filter value that passes every channel
   localparam logic signed [ListenWidth-1:0] LISTEN_ALL = -5'sd1;

   // channel message commands (status high nibble)
   localparam logic [3:0] CMD_NONE       = 4'h0;
   localparam logic [3:0] CMD_NOTE_OFF   = 4'h8;
   localparam logic [3:0] CMD_NOTE_ON    = 4'h9;
   localparam logic [3:0] CMD_AFTERTOUCH = 4'hA;
   localparam logic [3:0] CMD_CONTROL    = 4'hB;
   localparam logic [3:0] CMD_PROGRAM    = 4'hC;
   localparam logic [3:0] CMD_PRESSURE   = 4'hD;
   localparam logic [3:0] CMD_PITCH_BEND = 4'hE;
   localparam logic [3:0] CMD_SYSTEM     = 4'hF;

   // event code bank (upper two bits of event_code)
   localparam logic [1:0] BANK_NOTE_ON  = 2'd0;
   localparam logic [1:0] BANK_NOTE_OFF = 2'd1;
   localparam logic [1:0] BANK_CONTROL  = 2'd2;

   // realtime bytes start here
   localparam logic [RxByteWidth-1:0] REALTIME_FIRST = 8'hF8;

endpackage

`default_nettype wire

FILE: rtl/midi_byte_stream_event_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// MIDI byte stream parser with running status.
// req_*: one raw MIDI byte per request (tdata[7:0] = rx_byte).
// rsp_*: one event per completed note-on, note-off or controller message
//   whose channel passes the listen filter; other bytes give no event.
// csr_*: write of the 5-bit signed listen channel (-1 = all channels).
// Latency: an event appears on rsp_tvalid the cycle after the byte that
//   completes it is accepted. Throughput: one byte per cycle unless the
//   receiver stalls, set by the single output register that holds the event.
// When the receiver stalls, the held event stays on rsp_tdata and
//   req_tready drops until the event is taken; bytes that would give no
//   event are still blocked while the output register is full and stalled.
// Reset (synchronous, active high) clears running status, sets the
//   data-swallow flag, drops any pending event and sets the listen
//   channel to -1. csr_ready is always high.
module midi_byte_stream_event_parser_core (
   input  wire                                      clock,
   input  wire                                      reset,
   // request: [7:0] rx_byte
   input  wire                                      req_tvalid,
   output logic                                     req_tready,
   input  wire  [mbsep_pkg::RxByteWidth-1:0]        req_tdata,
   // response: [8:0] event_code, [15:9] event_value, [19:16] event_channel,
   //           [23:20] zero
   output logic                                     rsp_tvalid,
   input  wire                                      rsp_tready,
   output logic [mbsep_pkg::RspDataWidth-1:0]       rsp_tdata,
   // listen channel write
   input  wire                                      csr_valid,
   output logic                                     csr_ready,
   input  wire  signed [mbsep_pkg::ListenWidth-1:0] csr_data
);
   import mbsep_pkg::*;

`include "midi_byte_stream_event_parser_core_assert.svh"

   // running status state
   logic                           swallow_ff, swallow_in;
   logic [3:0]                     command_ff, command_in;
   logic [ChannelWidth-1:0]        channel_ff, channel_in;
   logic                           first_valid_ff, first_valid_in;
   logic [ValueWidth-1:0]          first_byte_ff, first_byte_in;
   logic signed [ListenWidth-1:0]  listen_ff, listen_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [CodeWidth-1:0]           code_ff, code_in;
   logic [ValueWidth-1:0]          value_ff, value_in;
   logic [ChannelWidth-1:0]        ev_channel_ff, ev_channel_in;

   logic                           req_fire;
   logic                           emit;
   logic                           chan_pass;
   logic [ValueWidth-1:0]          data_byte;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign data_byte  = req_tdata[ValueWidth-1:0];

   // listen filter against the running channel
   assign chan_pass = (listen_ff == LISTEN_ALL) ||
                      (!listen_ff[ListenWidth-1] &&
                       (listen_ff[ChannelWidth-1:0] == channel_ff));

   // byte decode and running status update
   always_comb begin
      swallow_in     = swallow_ff;
      command_in     = command_ff;
      channel_in     = channel_ff;
      first_valid_in = first_valid_ff;
      first_byte_in  = first_byte_ff;
      emit           = 1'b0;
      code_in        = {BANK_NOTE_ON, first_byte_ff};
      if (req_fire) begin
         if (req_tdata[RxByteWidth-1]) begin
            if (req_tdata >= REALTIME_FIRST) begin
               // realtime: no effect
            end else if (req_tdata[7:4] == CMD_SYSTEM) begin
               // F0-F3 start swallowing, F4-F7 end it
               swallow_in = !req_tdata[2];
            end else begin
               swallow_in     = 1'b0;
               command_in     = req_tdata[7:4];
               channel_in     = req_tdata[3:0];
               first_valid_in = 1'b0;
            end
         end else if (!swallow_ff) begin
            case (command_ff) inside
               CMD_NOTE_OFF, CMD_NOTE_ON, CMD_AFTERTOUCH,
               CMD_CONTROL, CMD_PITCH_BEND: begin
                  if (!first_valid_ff) begin
                     first_byte_in  = data_byte;
                     first_valid_in = 1'b1;
                  end else begin
                     first_valid_in = 1'b0;
                     if (command_ff == CMD_NOTE_ON && data_byte != '0) begin
                        code_in = {BANK_NOTE_ON, first_byte_ff};
                        emit    = chan_pass;
                     end else if (command_ff == CMD_NOTE_ON ||
                                  command_ff == CMD_NOTE_OFF) begin
                        code_in = {BANK_NOTE_OFF, first_byte_ff};
                        emit    = chan_pass;
                     end else if (command_ff == CMD_CONTROL) begin
                        code_in = {BANK_CONTROL, first_byte_ff};
                        emit    = chan_pass;
                     end
                  end
               end
               CMD_PROGRAM: begin
                  first_valid_in = 1'b0;
               end
               default: begin
                  // no command, or pressure: byte dropped
               end
            endcase
         end
      end
   end

   // output register load
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      value_in      = value_ff;
      ev_channel_in = ev_channel_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         value_in      = data_byte;
         ev_channel_in = channel_ff;
      end
   end

   // listen channel write
   always_comb begin
      listen_in = listen_ff;
      if (csr_valid && csr_ready) begin
         listen_in = csr_data;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         swallow_ff     <= 1'b1;
         command_ff     <= CMD_NONE;
         channel_ff     <= '0;
         first_valid_ff <= 1'b0;
         first_byte_ff  <= '0;
         listen_ff      <= LISTEN_ALL;
         rsp_valid_ff   <= 1'b0;
      end else begin
         swallow_ff     <= swallow_in;
         command_ff     <= command_in;
         channel_ff     <= channel_in;
         first_valid_ff <= first_valid_in;
         first_byte_ff  <= first_byte_in;
         listen_ff      <= listen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // event payload
   always_ff @(posedge clock) begin
      if (emit) begin
         code_ff <= code_in;
      end
      value_ff      <= value_in;
      ev_channel_ff <= ev_channel_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, ev_channel_ff, value_ff, code_ff};

   // checks
   `MBSEP_ASSERT_NOW(a_full_blocks_req, rsp_valid_ff && !rsp_tready, !req_tready, "request accepted while event stalled")
   `MBSEP_ASSERT_NOW(a_code_range, rsp_valid_ff, code_ff[CodeWidth-1:CodeWidth-2] != 2'b11, "event code out of range")
   `MBSEP_ASSERT_NEXT(a_realtime_keeps_state, req_fire && req_tdata >= REALTIME_FIRST, $stable(command_ff) && $stable(first_valid_ff) && $stable(swallow_ff), "realtime byte changed running status")
   `MBSEP_ASSERT_NEXT_ALWAYS(a_reset_swallow, reset, swallow_ff && !rsp_valid_ff, "reset did not set swallow state")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mbsep_pkg::*;

   // system common bytes up to this one start swallowing data bytes
   localparam logic [RxByteWidth-1:0] SYS_SWALLOW_LAST = 8'hF3;
   localparam logic [RxByteWidth-1:0] SYS_SWALLOW_END  = 8'hF7;
   localparam int IDLE_PCT       = 32;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int STEADY_FIRST   = 600;
   localparam int STEADY_LAST    = 1100;

   typedef struct packed {
      logic [ChannelWidth-1:0] channel;
      logic [ValueWidth-1:0]   value;
      logic [CodeWidth-1:0]    code;
   } midi_event_type;

   typedef enum logic [1:0] {ITEM_BYTE, ITEM_LISTEN, ITEM_DRAIN} item_kind_type;

   typedef struct {
      item_kind_type          kind;
      logic [RxByteWidth-1:0] data;
   } stim_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [RxByteWidth-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic signed [ListenWidth-1:0] csr_data = LISTEN_ALL;

   stim_item_type  byte_q[$];
   midi_event_type event_q[$];
   int error_cnt = 0;
   int cycle_cnt = 0;
   int settle_cnt = 0;
   int quiet_cnt = 0;
   bit req_taken = 1'b0;
   bit csr_taken = 1'b0;

   // parser state as predicted
   logic                          swallow_m;
   logic [3:0]                    cmd_m;
   logic [ChannelWidth-1:0]       chan_m;
   logic                          first_valid_m;
   logic [ValueWidth-1:0]         first_byte_m;
   logic signed [ListenWidth-1:0] listen_m;

   midi_byte_stream_event_parser_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   task report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      error_cnt++;
   endtask

   function bit steady_window();
      return cycle_cnt >= STEADY_FIRST && cycle_cnt < STEADY_LAST;
   endfunction

   function bit listen_passes(input logic [ChannelWidth-1:0] ch);
      return listen_m == LISTEN_ALL || (!listen_m[ListenWidth-1] && listen_m[3:0] == ch);
   endfunction

   // advance the running-status state by one byte; 1 when an event comes out
   function bit parse_midi_byte(input logic [RxByteWidth-1:0] b, output midi_event_type ev);
      ev = '0;
      if (b[7]) begin
         if (b >= REALTIME_FIRST) return 1'b0;
         if (b[7:4] == CMD_SYSTEM) begin
            swallow_m = (b <= SYS_SWALLOW_LAST);
            return 1'b0;
         end
         swallow_m     = 1'b0;
         cmd_m         = b[7:4];
         chan_m        = b[3:0];
         first_valid_m = 1'b0;
         return 1'b0;
      end
      if (swallow_m) return 1'b0;
      case (cmd_m)
         CMD_NOTE_OFF, CMD_NOTE_ON, CMD_AFTERTOUCH, CMD_CONTROL, CMD_PITCH_BEND: begin
            if (!first_valid_m) begin
               first_byte_m  = b[6:0];
               first_valid_m = 1'b1;
               return 1'b0;
            end
            first_valid_m = 1'b0;
            ev.channel    = chan_m;
            ev.value      = b[6:0];
            // note-on with zero velocity counts as note-off
            if (cmd_m == CMD_NOTE_ON && b[6:0] != 0)
               ev.code = {BANK_NOTE_ON, first_byte_m};
            else if (cmd_m == CMD_NOTE_ON || cmd_m == CMD_NOTE_OFF)
               ev.code = {BANK_NOTE_OFF, first_byte_m};
            else if (cmd_m == CMD_CONTROL)
               ev.code = {BANK_CONTROL, first_byte_m};
            else
               return 1'b0;
            return listen_passes(chan_m);
         end
         CMD_PROGRAM: first_valid_m = 1'b0;
         default: ;
      endcase
      return 1'b0;
   endfunction

   // monitor: check events, predict from accepted requests, watchdog
   always @(posedge clock) begin : monitor
      midi_event_type got, want, ev;
      bit rsp_fire;
      if (reset) begin
         swallow_m     = 1'b1;
         cmd_m         = CMD_NONE;
         chan_m        = '0;
         first_valid_m = 1'b0;
         first_byte_m  = '0;
         listen_m      = LISTEN_ALL;
         req_taken     = 1'b0;
         csr_taken     = 1'b0;
         settle_cnt    = 0;
      end else begin
         cycle_cnt++;
         req_taken = req_tvalid && req_tready;
         csr_taken = csr_valid && csr_ready;
         rsp_fire  = rsp_tvalid && rsp_tready;
         if (rsp_fire) begin
            got = rsp_tdata[19:0];
            if (event_q.size() == 0) begin
               report_mismatch("unexpected event code", got.code, -1);
            end else begin
               want = event_q.pop_front();
               if (got.code !== want.code)
                  report_mismatch("event_code", got.code, want.code);
               if (got.value !== want.value)
                  report_mismatch("event_value", got.value, want.value);
               if (got.channel !== want.channel)
                  report_mismatch("event_channel", got.channel, want.channel);
               if (rsp_tdata[23:20] !== 4'd0)
                  report_mismatch("tdata padding", rsp_tdata[23:20], 0);
            end
         end
         if (csr_taken) listen_m = csr_data;
         if (req_taken && parse_midi_byte(req_tdata, ev)) event_q.push_back(ev);
         settle_cnt = (event_q.size() == 0 && !req_taken) ? settle_cnt + 1 : 0;
         quiet_cnt  = (req_taken || csr_taken || rsp_fire) ? 0 : quiet_cnt + 1;
         if (quiet_cnt >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // driver: requests and listen writes from the pending queue
   always @(negedge clock) begin : driver
      stim_item_type head;
      logic nxt_valid, nxt_csr_valid;
      logic [RxByteWidth-1:0] nxt_data;
      logic signed [ListenWidth-1:0] nxt_csr_data;
      nxt_valid     = req_tvalid;
      nxt_data      = req_tdata;
      nxt_csr_valid = csr_valid;
      nxt_csr_data  = csr_data;
      if (!reset) begin
         if (req_tvalid && req_taken) nxt_valid = 1'b0;
         if (csr_valid && csr_taken) nxt_csr_valid = 1'b0;
         if (!nxt_valid && !nxt_csr_valid && byte_q.size() > 0) begin
            case (byte_q[0].kind)
               ITEM_BYTE: begin
                  if (steady_window() || $urandom_range(0, 99) >= IDLE_PCT) begin
                     head      = byte_q.pop_front();
                     nxt_valid = 1'b1;
                     nxt_data  = head.data;
                  end
               end
               // listen channel changes only once the parser is idle
               ITEM_LISTEN: begin
                  if (event_q.size() == 0 && settle_cnt >= SETTLE_CYCLES) begin
                     head          = byte_q.pop_front();
                     nxt_csr_valid = 1'b1;
                     nxt_csr_data  = head.data[ListenWidth-1:0];
                  end
               end
               ITEM_DRAIN: begin
                  if (event_q.size() == 0) head = byte_q.pop_front();
               end
               default: ;
            endcase
         end
      end
      req_tvalid <= nxt_valid;
      req_tdata  <= nxt_data;
      csr_valid  <= nxt_csr_valid;
      csr_data   <= nxt_csr_data;
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= steady_window() || $urandom_range(0, 99) >= IDLE_PCT;
   end

   task add_item(input item_kind_type kind, input logic [RxByteWidth-1:0] data);
      stim_item_type it;
      it.kind = kind;
      it.data = data;
      byte_q.push_back(it);
   endtask

   function logic [RxByteWidth-1:0] rand_data();
      return 8'($urandom_range(0, 127));
   endfunction

   // one phase of random traffic, mostly well-formed messages
   task add_random_phase(input int n_bytes, input logic signed [ListenWidth-1:0] lis);
      int start, pick, n_msgs, n_data;
      logic [3:0] cmd, ch;
      start = byte_q.size();
      add_item(ITEM_LISTEN, 8'(lis));
      while (byte_q.size() - start < n_bytes) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            case ($urandom_range(0, 9))
               0, 1, 2: cmd = CMD_NOTE_ON;
               3, 4:    cmd = CMD_NOTE_OFF;
               5, 6:    cmd = CMD_CONTROL;
               7:       cmd = CMD_AFTERTOUCH;
               8:       cmd = ($urandom_range(0, 1) != 0) ? CMD_PROGRAM : CMD_PRESSURE;
               default: cmd = CMD_PITCH_BEND;
            endcase
            if (!lis[ListenWidth-1] && $urandom_range(0, 1) != 0) ch = lis[3:0];
            else ch = 4'($urandom_range(0, 15));
            add_item(ITEM_BYTE, {cmd, ch});
            n_data = (cmd == CMD_PROGRAM || cmd == CMD_PRESSURE) ? 1 : 2;
            n_msgs = $urandom_range(1, 4);
            // running status: several messages after one status byte
            for (int m = 0; m < n_msgs * n_data; m++) begin
               if ($urandom_range(0, 9) == 0)
                  add_item(ITEM_BYTE, 8'($urandom_range(REALTIME_FIRST, 255)));
               if (m % n_data == 1 && $urandom_range(0, 6) == 0)
                  add_item(ITEM_BYTE, 8'h00);
               else
                  add_item(ITEM_BYTE, rand_data());
            end
         end else if (pick < 85) begin
            // system exclusive style block
            add_item(ITEM_BYTE, 8'($urandom_range(8'hF0, SYS_SWALLOW_LAST)));
            repeat ($urandom_range(0, 5)) add_item(ITEM_BYTE, rand_data());
            if ($urandom_range(0, 3) != 0) add_item(ITEM_BYTE, SYS_SWALLOW_END);
            else add_item(ITEM_BYTE, 8'($urandom_range(8'hF4, SYS_SWALLOW_END)));
         end else begin
            add_item(ITEM_BYTE, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      logic [RxByteWidth-1:0] directed[$];
      // data with no command, note-on extremes, zero velocity, realtime inside
      // a message, note-off on channel 15, top controller, sysex swallow,
      // and the commands that give no event
      directed = '{8'hF4, 8'h55,
                   8'h90, 8'h00, 8'h7F, 8'h7F, 8'h00, 8'h3C, 8'hF8, 8'h40,
                   8'h8F, 8'h7F, 8'h01, 8'hBA, 8'h7F, 8'h00,
                   8'hF0, 8'h11, 8'hF7,
                   8'hA1, 8'h10, 8'h20, 8'hC2, 8'h05, 8'hD3, 8'h10,
                   8'hE4, 8'h00, 8'h7F, 8'hFF};
      foreach (directed[i]) add_item(ITEM_BYTE, directed[i]);

      add_random_phase(170, 5'sd0);
      add_random_phase(170, 5'sd15);
      add_random_phase(80, -5'sd16);
      add_random_phase(80, -5'sd2);
      add_random_phase(170, LISTEN_ALL);
      // sender holds until every pending event has come back
      add_item(ITEM_DRAIN, 8'h00);
      add_random_phase(170, 5'($urandom_range(0, 15)));
      add_random_phase(170, LISTEN_ALL);

      @(negedge reset);
      while (byte_q.size() != 0 || req_tvalid || csr_valid || event_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_cnt == 0 && event_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mbsep_pkg.sv
rtl/midi_byte_stream_event_parser_core.sv
tb/testbench.sv
